@@ hw/rtl/arfd_pkg.sv @@
// Shared codes, widths and constants for the ring fault diagnosis block.
package arfd_pkg;

  // Field widths fixed by the item format
  localparam int NODE_W = 4;
  localparam int MODE_W = 2;
  localparam int CFG_W  = 5;

  // Node indexes carry four bits, so no ring holds more than sixteen nodes
  localparam int RING_CAP = 16;

  // Ring size after reset
  localparam logic [CFG_W-1:0] NUM_NODES_RESET = 5'd8;
  localparam logic [CFG_W-1:0] RING_MIN        = 5'd2;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_TEST   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FAULT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_REPAIR = 2'd2;
  localparam logic [MODE_W-1:0] MODE_READ   = 2'd3;

  // Operations of the shared counter unit
  localparam int OP_W = 2;
  localparam logic [OP_W-1:0] OP_SELF  = 2'd0;
  localparam logic [OP_W-1:0] OP_PROBE = 2'd1;
  localparam logic [OP_W-1:0] OP_MAX   = 2'd2;

endpackage

@@ hw/rtl/arfd_alu.sv @@
// Shared counter unit: self-entry init, probe parity step and merge maximum.
module arfd_alu
  import arfd_pkg::*;
#(
  parameter int CW = 16
) (
  input  logic [OP_W-1:0]       op,
  input  logic signed [CW-1:0]  cur,
  input  logic signed [CW-1:0]  src,
  input  logic                  status,
  input  logic                  skip,
  output logic signed [CW-1:0]  res,
  output logic                  wr
);

  localparam logic signed [CW-1:0] MINUS_ONE = '1;
  localparam logic signed [CW-1:0] CMAX      = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] ONE       = {{(CW-1){1'b0}}, 1'b1};

  // Pick the new entry value and whether it goes back to the table
  always_comb begin
    res = cur;
    wr  = 1'b0;
    case (op)
      OP_SELF: begin
        res = '0;
        wr  = (cur == MINUS_ONE);
      end
      OP_PROBE: begin
        wr = 1'b1;
        if (cur == MINUS_ONE) begin
          res = {{(CW-1){1'b0}}, status};
        end else if (cur[0] != status) begin
          // largest count is odd; wrap to zero keeps the parity flip
          res = (cur == CMAX) ? '0 : cur + ONE;
        end
      end
      OP_MAX: begin
        res = src;
        wr  = !skip && (src > cur);
      end
      default: begin
        res = cur;
        wr  = 1'b0;
      end
    endcase
  end

endmodule

@@ hw/rtl/arfd_table.sv @@
// Diagnosis table: counter memory with per-entry valid bits and registered read.
module arfd_table
  import arfd_pkg::*;
#(
  parameter int AW = 8,
  parameter int CW = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic signed [CW-1:0] wdata,
  input  logic [AW-1:0]        raddr,
  output logic signed [CW-1:0] rdata
);

  localparam int DEPTH = 1 << AW;

  logic signed [CW-1:0] mem [DEPTH];
  logic [DEPTH-1:0]     valid;
  logic signed [CW-1:0] rdata_q;
  logic                 rvalid_q;

  // Write and read the counter storage
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Track written entries; unwritten ones read as unknown
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      rvalid_q <= valid[raddr];
    end
  end

  assign rdata = rvalid_q ? rdata_q : '1;

endmodule

@@ hw/rtl/adaptive_ring_fault_diagnosis_top.sv @@
// Top level: item sequencer, fault flags, ring size register and result port.
//
//  channel   signals                                   handshake
//  input     start, mode, node, peer                   start && !busy
//  config    cfg_valid, cfg_data -> cfg_ready          cfg_valid && cfg_ready
//  result    result_valid, tester, tested,             one-cycle strobe
//            tested_faulty, entry_value, last
//
// A test item checks its self entry, reads and updates one entry per probe and,
// if it ends on a fault-free node, reads the source and own entry and compares
// for each ring node; the single table read port takes one access per cycle. A
// read item passes the read-out state; fault and repair items end at the accept
// edge. Reset clears every table valid bit and all fault flags at once. The
// result side never stalls; each result is shown for one cycle after its probe.
module adaptive_ring_fault_diagnosis_top
  import arfd_pkg::*;
#(
  parameter int MAX_NODES   = 16,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [MODE_W-1:0]             mode,
  input  logic [NODE_W-1:0]             node,
  input  logic [NODE_W-1:0]             peer,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [CFG_W-1:0]              cfg_data,
  output logic                          result_valid,
  output logic [NODE_W-1:0]             tester,
  output logic [NODE_W-1:0]             tested,
  output logic                          tested_faulty,
  output logic signed [COUNT_WIDTH-1:0] entry_value,
  output logic                          last
);

  localparam int ROWS = (MAX_NODES < RING_CAP) ? MAX_NODES : RING_CAP;
  localparam int RW   = $clog2(ROWS);
  localparam int AW   = RW + NODE_W;
  localparam int CW   = COUNT_WIDTH;
  localparam logic [CFG_W-1:0] ROWS_C = CFG_W'(ROWS);
  localparam logic signed [CW-1:0] MINUS_ONE = '1;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SELF_RD  = 4'd1;
  localparam logic [3:0] S_SELF_CHK = 4'd2;
  localparam logic [3:0] S_PRB_RD   = 4'd3;
  localparam logic [3:0] S_PRB_UPD  = 4'd4;
  localparam logic [3:0] S_MRG_SRC  = 4'd5;
  localparam logic [3:0] S_MRG_DST  = 4'd6;
  localparam logic [3:0] S_MRG_CMP  = 4'd7;
  localparam logic [3:0] S_RD_OUT   = 4'd8;

  logic [3:0]             state;
  logic [CFG_W-1:0]       num_nodes;
  logic [ROWS-1:0]        fault_flags;
  logic [NODE_W-1:0]      t;
  logic [NODE_W-1:0]      d;
  logic [CFG_W-1:0]       idx;
  logic                   read_ok;
  logic signed [CW-1:0]   src;

  logic [CFG_W-1:0]       ring_n;
  logic [CFG_W-1:0]       d_inc;
  logic [NODE_W-1:0]      d_next;
  logic [CFG_W-1:0]       node_inc;
  logic [NODE_W-1:0]      first_d;
  logic [CFG_W-1:0]       idx_inc;
  logic                   node_in_ring;
  logic                   node_in_rows;
  logic                   peer_in_rows;

  logic [OP_W-1:0]        alu_op;
  logic                   alu_status;
  logic                   alu_skip;
  logic signed [CW-1:0]   alu_res;
  logic                   alu_wr;

  logic                   tbl_we;
  logic [AW-1:0]          tbl_waddr;
  logic [AW-1:0]          tbl_raddr;
  logic signed [CW-1:0]   tbl_rdata;
  logic                   d_faulty;

  // Take a ring size write only between items
  assign cfg_ready = !busy;
  assign busy      = (state != S_IDLE);

  // Clamp the configured ring size to the supported range
  always_comb begin
    if (num_nodes < RING_MIN) begin
      ring_n = RING_MIN;
    end else if (num_nodes > ROWS_C) begin
      ring_n = ROWS_C;
    end else begin
      ring_n = num_nodes;
    end
  end

  // Ring successor and merge index stepping
  assign d_inc        = {1'b0, d} + CFG_W'(1);
  assign d_next       = (d_inc == ring_n) ? '0 : d_inc[NODE_W-1:0];
  assign node_inc     = {1'b0, node} + CFG_W'(1);
  assign first_d      = (node_inc == ring_n) ? '0 : node_inc[NODE_W-1:0];
  assign idx_inc      = idx + CFG_W'(1);
  assign node_in_ring = ({1'b0, node} < ring_n);
  assign node_in_rows = ({1'b0, node} < ROWS_C);
  assign peer_in_rows = ({1'b0, peer} < ROWS_C);
  assign d_faulty     = fault_flags[d[RW-1:0]];

  // Select the shared unit's operation by sequencer step
  always_comb begin
    alu_op     = OP_SELF;
    alu_status = d_faulty;
    alu_skip   = (idx[NODE_W-1:0] == d);
    unique case (state)
      S_PRB_UPD: alu_op = OP_PROBE;
      S_MRG_CMP: alu_op = OP_MAX;
      default:   alu_op = OP_SELF;
    endcase
  end

  arfd_alu #(
    .CW(CW)
  ) u_alu (
    .op    (alu_op),
    .cur   (tbl_rdata),
    .src   (src),
    .status(alu_status),
    .skip  (alu_skip),
    .res   (alu_res),
    .wr    (alu_wr)
  );

  // Table addresses and write enable
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = {t[RW-1:0], t};
    tbl_raddr = {t[RW-1:0], t};
    unique case (state)
      S_IDLE:     tbl_raddr = {node[RW-1:0], peer};
      S_SELF_RD:  tbl_raddr = {t[RW-1:0], t};
      S_SELF_CHK: begin
        tbl_we    = alu_wr;
        tbl_waddr = {t[RW-1:0], t};
      end
      S_PRB_RD:   tbl_raddr = {t[RW-1:0], d};
      S_PRB_UPD:  begin
        tbl_we    = alu_wr;
        tbl_waddr = {t[RW-1:0], d};
      end
      S_MRG_SRC:  tbl_raddr = {d[RW-1:0], idx[NODE_W-1:0]};
      S_MRG_DST:  tbl_raddr = {t[RW-1:0], idx[NODE_W-1:0]};
      S_MRG_CMP:  begin
        tbl_we    = alu_wr;
        tbl_waddr = {t[RW-1:0], idx[NODE_W-1:0]};
      end
      default:    tbl_we = 1'b0;
    endcase
  end

  arfd_table #(
    .AW(AW),
    .CW(CW)
  ) u_table (
    .clk  (clk),
    .rst  (rst),
    .we   (tbl_we),
    .waddr(tbl_waddr),
    .wdata(alu_res),
    .raddr(tbl_raddr),
    .rdata(tbl_rdata)
  );

  // Hold the ring size register
  always_ff @(posedge clk) begin
    if (rst) begin
      num_nodes <= NUM_NODES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      num_nodes <= cfg_data;
    end
  end

  // Sequence each item through the table
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      fault_flags  <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            t       <= node;
            d       <= first_d;
            read_ok <= node_in_rows && peer_in_rows;
            unique case (mode)
              MODE_TEST: begin
                if (node_in_ring && !fault_flags[node[RW-1:0]]) begin
                  state <= S_SELF_RD;
                end
              end
              MODE_FAULT, MODE_REPAIR: begin
                if (node_in_rows) begin
                  fault_flags[node[RW-1:0]] <= (mode == MODE_FAULT);
                end
              end
              MODE_READ: begin
                d     <= peer;
                state <= S_RD_OUT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SELF_RD:  state <= S_SELF_CHK;
        S_SELF_CHK: state <= S_PRB_RD;
        S_PRB_RD:   state <= S_PRB_UPD;
        S_PRB_UPD: begin
          // emit this probe; a fault-free node or the tester itself ends it
          result_valid  <= 1'b1;
          tester        <= t;
          tested        <= d;
          tested_faulty <= d_faulty;
          entry_value   <= alu_res;
          last          <= !d_faulty || (d == t);
          if (!d_faulty) begin
            idx   <= '0;
            state <= S_MRG_SRC;
          end else if (d == t) begin
            state <= S_IDLE;
          end else begin
            d     <= d_next;
            state <= S_PRB_RD;
          end
        end
        S_MRG_SRC: state <= S_MRG_DST;
        S_MRG_DST: begin
          src   <= tbl_rdata;
          state <= S_MRG_CMP;
        end
        S_MRG_CMP: begin
          idx <= idx_inc;
          if (idx_inc == ring_n) begin
            state <= S_IDLE;
          end else begin
            state <= S_MRG_SRC;
          end
        end
        S_RD_OUT: begin
          result_valid  <= 1'b1;
          tester        <= t;
          tested        <= d;
          tested_faulty <= read_ok && fault_flags[d[RW-1:0]];
          entry_value   <= read_ok ? tbl_rdata : MINUS_ONE;
          last          <= 1'b1;
          state         <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // Results come only from a probe step or a read-out step
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(state) == S_PRB_UPD || $past(state) == S_RD_OUT))
    else $error("result strobe outside a probe or read step");

  // No table write while the sequencer is idle
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !tbl_we)
    else $error("table written while idle");

  // After a final result the sequencer is idle or merging
  assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |-> (state == S_IDLE || state == S_MRG_SRC))
    else $error("final result but item still probing");

  // A probing tester is never faulty
  assert property (@(posedge clk) disable iff (rst)
    (state == S_PRB_UPD) |-> !fault_flags[t[RW-1:0]])
    else $error("faulty node acting as tester");
`endif

endmodule

@@ tb/adaptive_ring_fault_diagnosis_top_tb.sv @@
// Self-checking testbench for the ring fault diagnosis block: probes, merges, reads.
module adaptive_ring_fault_diagnosis_top_tb;
  import arfd_pkg::*;

  localparam int MAX_NODES   = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int CNT_MAX     = (1 << (COUNT_WIDTH - 1)) - 1;
  // Cycles of quiet before a ring size write
  localparam int SETTLE      = 100;

  typedef enum {ACT_ITEM, ACT_RING, ACT_DRAIN} act_t;

  typedef struct {
    act_t              kind;
    logic [MODE_W-1:0] mode;
    logic [NODE_W-1:0] node;
    logic [NODE_W-1:0] peer;
    logic [CFG_W-1:0]  ring;
    int                gap;
  } stim_t;

  typedef struct {
    logic [NODE_W-1:0]             tester;
    logic [NODE_W-1:0]             tested;
    logic                          faulty;
    logic signed [COUNT_WIDTH-1:0] value;
    logic                          last;
  } probe_rec_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic [MODE_W-1:0]             mode = MODE_READ;
  logic [NODE_W-1:0]             node = '0;
  logic [NODE_W-1:0]             peer = '0;
  logic                          cfg_valid = 1'b0;
  logic [CFG_W-1:0]              cfg_data = NUM_NODES_RESET;
  logic                          busy;
  logic                          cfg_ready;
  logic                          result_valid;
  logic [NODE_W-1:0]             tester;
  logic [NODE_W-1:0]             tested;
  logic                          tested_faulty;
  logic signed [COUNT_WIDTH-1:0] entry_value;
  logic                          last;

  // Predicted block state
  int               seen_count [RING_CAP][RING_CAP];
  bit               node_down [RING_CAP];
  logic [CFG_W-1:0] ring_cfg;

  // Generator view of the fault flags, kept in step with the queued items
  bit               gen_down [RING_CAP];
  int               gen_ring;

  stim_t      items_todo [$];
  probe_rec_t probes_due [$];
  probe_rec_t want;
  int         bad_count = 0;
  int         gap_left = 0;
  int         quiet = 0;
  logic       nxt_start;
  logic       nxt_cfg;

  adaptive_ring_fault_diagnosis_top #(
    .MAX_NODES  (MAX_NODES),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .node         (node),
    .peer         (peer),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .tester       (tester),
    .tested       (tested),
    .tested_faulty(tested_faulty),
    .entry_value  (entry_value),
    .last         (last)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Clamp the register value to the ring size in use
  function automatic int ring_of(logic [CFG_W-1:0] v);
    int n;
    n = int'(v);
    if (n < int'(RING_MIN)) n = int'(RING_MIN);
    if (n > MAX_NODES) n = MAX_NODES;
    if (n > RING_CAP) n = RING_CAP;
    return n;
  endfunction

  // One probe of node d by node t; returns the fault flag seen
  function automatic bit probe_node(int t, int d, int n);
    bit st;
    int v;
    st = node_down[d];
    if (seen_count[t][t] == -1) seen_count[t][t] = 0;
    v = seen_count[t][d];
    if (v == -1) begin
      seen_count[t][d] = int'(st);
    end else if (v[0] != st) begin
      seen_count[t][d] = (v >= CNT_MAX) ? 0 : v + 1;
    end
    // Merge the healthy node's view, leaving its own column alone
    if (!st) begin
      for (int i = 0; i < n; i++) begin
        if (i != d && seen_count[d][i] > seen_count[t][i]) seen_count[t][i] = seen_count[d][i];
      end
    end
    return st;
  endfunction

  // Apply one accepted item to the predicted state and queue its results
  function automatic void diagnose_item(logic [MODE_W-1:0] m, logic [NODE_W-1:0] nd,
                                        logic [NODE_W-1:0] pr);
    int         n;
    int         off;
    int         d;
    bit         st;
    bit         done;
    int         v;
    probe_rec_t rec;
    n = ring_of(ring_cfg);
    case (m)
      MODE_TEST: begin
        if (int'(nd) < n && !node_down[nd]) begin
          off = 1;
          done = 1'b0;
          while (!done && off <= n) begin
            d = (int'(nd) + off) % n;
            st = probe_node(int'(nd), d, n);
            done = !st || d == int'(nd);
            v = seen_count[nd][d];
            rec.tester = nd;
            rec.tested = NODE_W'(d);
            rec.faulty = st;
            rec.value = v[COUNT_WIDTH-1:0];
            rec.last = done;
            probes_due.push_back(rec);
            off++;
          end
        end
      end
      MODE_FAULT, MODE_REPAIR: begin
        if (int'(nd) < MAX_NODES) node_down[nd] = (m == MODE_FAULT);
      end
      default: begin
        rec.tester = nd;
        rec.tested = pr;
        rec.last = 1'b1;
        if (int'(nd) < MAX_NODES && int'(pr) < MAX_NODES) begin
          v = seen_count[nd][pr];
          rec.faulty = node_down[pr];
          rec.value = v[COUNT_WIDTH-1:0];
        end else begin
          rec.faulty = 1'b0;
          rec.value = '1;
        end
        probes_due.push_back(rec);
      end
    endcase
  endfunction

  function automatic void queue_item(logic [MODE_W-1:0] m, int nd, int pr, int gap);
    stim_t s;
    s.kind = ACT_ITEM;
    s.mode = m;
    s.node = NODE_W'(nd);
    s.peer = NODE_W'(pr);
    s.ring = '0;
    s.gap = gap;
    items_todo.push_back(s);
    if (m == MODE_FAULT || m == MODE_REPAIR) gen_down[nd[3:0]] = (m == MODE_FAULT);
  endfunction

  function automatic void queue_ring(logic [CFG_W-1:0] val);
    stim_t s;
    s.kind = ACT_RING;
    s.mode = MODE_READ;
    s.node = '0;
    s.peer = '0;
    s.ring = val;
    s.gap = 0;
    items_todo.push_back(s);
    gen_ring = ring_of(val);
  endfunction

  function automatic void queue_drain();
    stim_t s;
    s.kind = ACT_DRAIN;
    s.mode = MODE_READ;
    s.node = '0;
    s.peer = '0;
    s.ring = '0;
    s.gap = 0;
    items_todo.push_back(s);
  endfunction

  // Driver: present items and ring size writes, predict on each accept
  always @(posedge clk) begin
    if (!rst) begin
      nxt_start = start;
      nxt_cfg = cfg_valid;
      if (start && !busy) begin
        diagnose_item(mode, node, peer);
        nxt_start = 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        ring_cfg = cfg_data;
        nxt_cfg = 1'b0;
      end
      if (result_valid || (start && !busy)) quiet = 0;
      else if (quiet < SETTLE) quiet++;
      // Advance to the next pending action once the port is free
      if (!nxt_start && !nxt_cfg && items_todo.size() > 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else begin
          case (items_todo[0].kind)
            ACT_ITEM: begin
              mode <= items_todo[0].mode;
              node <= items_todo[0].node;
              peer <= items_todo[0].peer;
              nxt_start = 1'b1;
              gap_left = items_todo[0].gap;
              void'(items_todo.pop_front());
            end
            ACT_RING: begin
              if (probes_due.size() == 0 && quiet >= SETTLE) begin
                cfg_data <= items_todo[0].ring;
                nxt_cfg = 1'b1;
                void'(items_todo.pop_front());
              end
            end
            default: begin
              if (probes_due.size() == 0 && quiet >= SETTLE) void'(items_todo.pop_front());
            end
          endcase
        end
      end
      start <= nxt_start;
      cfg_valid <= nxt_cfg;
    end
  end

  // Monitor: check every strobed result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (probes_due.size() == 0) begin
        bad_count++;
        if (bad_count <= 10)
          $display("unexpected result: tester %0d tested %0d faulty %0d value %0d last %0d",
                   tester, tested, tested_faulty, entry_value, last);
      end else begin
        want = probes_due.pop_front();
        if (tester !== want.tester || tested !== want.tested || tested_faulty !== want.faulty ||
            entry_value !== want.value || last !== want.last) begin
          bad_count++;
          if (bad_count <= 10)
            $display("mismatch: expected %0d/%0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d/%0d",
                     want.tester, want.tested, want.faulty, want.value, want.last,
                     tester, tested, tested_faulty, entry_value, last);
        end
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin
    logic [CFG_W-1:0] ring_list [10];
    int               n;
    int               r;
    int               nd;
    int               tries;
    int               down_cnt;
    int               gmax;

    for (int i = 0; i < RING_CAP; i++) begin
      node_down[i] = 1'b0;
      gen_down[i] = 1'b0;
      for (int j = 0; j < RING_CAP; j++) seen_count[i][j] = -1;
    end
    ring_cfg = NUM_NODES_RESET;
    gen_ring = ring_of(NUM_NODES_RESET);

    // Directed: unknown entries, first probe, faulty chains, ignored tests, ring wrap
    queue_item(MODE_READ, 0, 0, 0);
    queue_item(MODE_READ, 15, 15, 2);
    queue_item(MODE_TEST, 0, 0, 0);
    queue_item(MODE_FAULT, 1, 0, 0);
    queue_item(MODE_FAULT, 2, 0, 1);
    queue_item(MODE_TEST, 0, 15, 0);
    queue_item(MODE_TEST, 1, 0, 0);
    queue_item(MODE_TEST, 9, 0, 3);
    queue_item(MODE_TEST, 7, 0, 0);
    queue_item(MODE_REPAIR, 1, 0, 0);
    queue_item(MODE_TEST, 0, 0, 0);
    queue_item(MODE_READ, 0, 1, 0);
    queue_item(MODE_FAULT, 15, 0, 0);
    queue_item(MODE_READ, 3, 15, 0);
    queue_item(MODE_REPAIR, 15, 0, 0);
    queue_item(MODE_TEST, 3, 0, 0);
    // Pause until everything is out, then shrink to the smallest ring
    queue_drain();
    queue_ring(5'd2);
    queue_item(MODE_FAULT, 1, 0, 0);
    queue_item(MODE_TEST, 0, 0, 0);
    queue_item(MODE_TEST, 1, 0, 0);
    queue_item(MODE_REPAIR, 1, 0, 0);
    queue_item(MODE_REPAIR, 2, 0, 0);
    queue_item(MODE_TEST, 1, 0, 0);
    queue_ring(5'd16);
    queue_item(MODE_TEST, 15, 0, 0);
    queue_item(MODE_READ, 15, 0, 0);
    queue_item(MODE_READ, 10, 5, 0);

    // Random phases over a spread of ring sizes, out-of-range values included
    ring_list = '{5'd0, 5'd1, 5'd3, 5'd5, 5'd8, 5'd12, 5'd16, 5'd17, 5'd31, 5'd2};
    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 4) queue_drain();
      queue_ring(ring_list[ph]);
      n = gen_ring;
      gmax = ($urandom_range(0, 3) == 0) ? 0 : 6;
      for (int k = 0; k < 35; k++) begin
        r = $urandom_range(0, 99);
        down_cnt = 0;
        for (int i = 0; i < n; i++) down_cnt += int'(gen_down[i]);
        if (r < 50) begin
          // Test by a healthy node where one can be found quickly
          nd = $urandom_range(0, n - 1);
          tries = 0;
          while (gen_down[nd] && tries < 4) begin
            nd = $urandom_range(0, n - 1);
            tries++;
          end
          queue_item(MODE_TEST, nd, $urandom_range(0, 15), $urandom_range(0, gmax));
        end else if (r < 65 && down_cnt < n - 1) begin
          queue_item(MODE_FAULT, $urandom_range(0, n - 1), $urandom_range(0, 15),
                     $urandom_range(0, gmax));
        end else if (r < 80) begin
          queue_item(MODE_REPAIR, $urandom_range(0, n - 1), $urandom_range(0, 15),
                     $urandom_range(0, gmax));
        end else if (r < 92) begin
          queue_item(MODE_READ, $urandom_range(0, 15), $urandom_range(0, 15),
                     $urandom_range(0, gmax));
        end else begin
          queue_item(MODE_W'($urandom_range(0, 3)), $urandom_range(0, 15),
                     $urandom_range(0, 15), $urandom_range(0, gmax));
        end
      end
    end
    queue_item(MODE_READ, 0, 1, 0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (items_todo.size() > 0 || start || cfg_valid || probes_due.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (bad_count == 0 && probes_due.size() == 0) begin
      $display("adaptive_ring_fault_diagnosis_top_tb: done, clean");
    end else begin
      $display("adaptive_ring_fault_diagnosis_top_tb: done, errors");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #2000000;
    $display("adaptive_ring_fault_diagnosis_top_tb: done, errors");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/arfd_pkg.sv
hw/rtl/arfd_alu.sv
hw/rtl/arfd_table.sv
hw/rtl/adaptive_ring_fault_diagnosis_top.sv
tb/adaptive_ring_fault_diagnosis_top_tb.sv
